@@ rtl/core/nps_pkg.sv @@
// ---------------------------------------------------------------------------
// nps_pkg: shared types and constants of the priority scheduler
// Request and result payloads, the control struct broadcast to the slot
// cells and the status struct that each cell reports back.
// ---------------------------------------------------------------------------
`default_nettype none
package nps_pkg;

    localparam int MAX_PROCS = 16;
    localparam int IDX_W     = $clog2(MAX_PROCS);
    localparam int CNT_W     = $clog2(MAX_PROCS + 1);
    localparam int SLOT_W    = 4;
    localparam int TIME_W    = 16;
    localparam int DUR_W     = 8;
    localparam int PRIO_W    = 8;
    localparam int PCNT_W    = 5;

    localparam logic       CMD_LOAD  = 1'b0;
    localparam logic       CMD_TICK  = 1'b1;
    localparam logic [1:0] ST_ABSENT = 2'd0;
    localparam logic [1:0] ST_READY  = 2'd1;
    localparam logic [1:0] ST_RUN    = 2'd2;

    typedef struct packed {
        logic              cmd;
        logic [SLOT_W-1:0] slot;
        logic [DUR_W-1:0]  duration;
        logic [PRIO_W-1:0] priority_req;
        logic [TIME_W-1:0] arrival_time;
    } in_req_t;

    typedef struct packed {
        logic [TIME_W-1:0] tick_time;
        logic [SLOT_W-1:0] slot_res;
        logic [1:0]        status;
        logic              last;
        logic              all_done;
    } out_res_t;

    // Sort key that travels around the ring of cells.
    typedef struct packed {
        logic              waiting;
        logic [PRIO_W-1:0] prio;
        logic [TIME_W-1:0] arrival;
        logic [CNT_W-1:0]  rank;
    } ring_key_t;

    typedef struct packed {
        logic             load;
        logic             admit;
        logic [CNT_W-1:0] admit_rank;
        logic             ring_load;
        logic             ring_step;
        logic             commit;
        logic             run;
        logic             run_fin;
    } cell_ctrl_t;

    typedef struct packed {
        logic       eligible;
        logic       queued;
        logic       head_fin;
        logic       busy;
        logic [1:0] stat;
    } cell_info_t;

endpackage
`default_nettype wire

@@ rtl/core/nps_cell.sv @@
// ---------------------------------------------------------------------------
// nps_cell: one process slot of the scheduler
// Holds the slot's remaining time, priority, arrival tick and queue rank,
// and ranks itself by counting the waiting keys that pass it on the ring.
// ---------------------------------------------------------------------------
`default_nettype none
module nps_cell (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire nps_pkg::cell_ctrl_t       ctrl,
    input  wire logic                      sel,
    input  wire nps_pkg::in_req_t          req,
    input  wire logic [nps_pkg::TIME_W-1:0] now,
    input  wire nps_pkg::ring_key_t        ring_in,
    output nps_pkg::ring_key_t             ring_out,
    output nps_pkg::cell_info_t            info
);
    import nps_pkg::*;

    logic [DUR_W-1:0]  rem_reg, rem_next;
    logic [PRIO_W-1:0] prio_reg, prio_next;
    logic [TIME_W-1:0] arr_reg, arr_next;
    logic [CNT_W-1:0]  rank_reg, rank_next;
    logic              retired_reg, retired_next;
    logic [1:0]        stat_reg, stat_next;
    ring_key_t         ring_reg, ring_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    ring_key_t         own_key;
    logic              waiting, is_head, passes_me;

    assign waiting = rank_reg >= CNT_W'(2);
    assign is_head = rank_reg == CNT_W'(1);
    assign own_key = '{waiting: waiting, prio: prio_reg, arrival: arr_reg, rank: rank_reg};
    assign passes_me = waiting && ring_reg.waiting &&
        ({ring_reg.prio, ring_reg.arrival, ring_reg.rank} <
         {prio_reg, arr_reg, rank_reg});

    always_comb begin
        rem_next     = rem_reg;
        prio_next    = prio_reg;
        arr_next     = arr_reg;
        rank_next    = rank_reg;
        retired_next = retired_reg;
        stat_next    = stat_reg;
        ring_next    = ring_reg;
        cnt_next     = cnt_reg;
        if (ctrl.load && sel) begin
            rem_next     = req.duration;
            prio_next    = req.priority_req;
            arr_next     = req.arrival_time;
            retired_next = 1'b0;
        end
        if (ctrl.admit && sel) begin
            rank_next = ctrl.admit_rank;
        end
        if (ctrl.ring_load) begin
            ring_next = own_key;
            cnt_next  = '0;
        end
        if (ctrl.ring_step) begin
            ring_next = ring_in;
            cnt_next  = cnt_reg + CNT_W'(passes_me);
        end
        if (ctrl.commit) begin
            if (waiting) begin
                rank_next = cnt_reg + CNT_W'(2);
            end
            stat_next = is_head ? ST_RUN : (waiting ? ST_READY : ST_ABSENT);
        end
        if (ctrl.run) begin
            if (is_head && rem_reg != '0) begin
                rem_next = rem_reg - DUR_W'(1);
            end
            if (ctrl.run_fin) begin
                if (is_head) begin
                    retired_next = 1'b1;
                end
                if (rank_reg != '0) begin
                    rank_next = rank_reg - CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg     <= '0;
            prio_reg    <= '0;
            arr_reg     <= '0;
            rank_reg    <= '0;
            retired_reg <= 1'b0;
            stat_reg    <= ST_ABSENT;
        end else begin
            rem_reg     <= rem_next;
            prio_reg    <= prio_next;
            arr_reg     <= arr_next;
            rank_reg    <= rank_next;
            retired_reg <= retired_next;
            stat_reg    <= stat_next;
        end
        ring_reg <= ring_next;
        cnt_reg  <= cnt_next;
    end

    assign ring_out      = ring_reg;
    assign info.eligible = (rank_reg == '0) && !retired_reg && (rem_reg != '0) &&
                           (arr_reg == now);
    assign info.queued   = rank_reg != '0;
    assign info.head_fin = is_head && (rem_reg <= DUR_W'(1));
    assign info.busy     = rem_reg != '0;
    assign info.stat     = stat_reg;

endmodule
`default_nettype wire

@@ rtl/core/nonpreemptive_priority_scheduler.sv @@
// ---------------------------------------------------------------------------
// nonpreemptive_priority_scheduler: tick-by-tick priority scheduler
// A request on s_ either loads a process slot (no result) or advances
// one tick. A tick scans the slots in use for admission, one slot at a
// time, ranks the waiting entries by circulating their keys once around
// the ring of slot cells, runs the head and settles the done flag, then
// sends one status row per slot in use on m_, one per cycle while
// m_ready is high. s_ready is high only while no tick is in progress;
// the last row may still wait in the output register while the next
// request is taken. A stalled m_ready holds the current row and pauses
// the tick. The process_count register is written through
// cfg_wr_en/cfg_wr_data. aresetn (synchronous, low) clears all slots,
// the queue and the time, and sets process_count to 16.
// ---------------------------------------------------------------------------
`default_nettype none
module nonpreemptive_priority_scheduler (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire nps_pkg::in_req_t           s_data,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output nps_pkg::out_res_t               m_data,
    input  wire logic                       cfg_wr_en,
    input  wire logic [nps_pkg::PCNT_W-1:0] cfg_wr_data
);
    import nps_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_ADMIT  = 3'd1;
    localparam logic [2:0] S_RLOAD  = 3'd2;
    localparam logic [2:0] S_RSHIFT = 3'd3;
    localparam logic [2:0] S_COMMIT = 3'd4;
    localparam logic [2:0] S_RUN    = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;
    localparam logic [2:0] S_EMIT   = 3'd7;

    logic [2:0]        state_reg, state_next;
    logic [PCNT_W-1:0] pcount_reg;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  qlen_reg, qlen_next;
    logic [TIME_W-1:0] now_reg, now_next;
    logic [TIME_W-1:0] tick_reg, tick_next;
    logic              done_reg, done_next;
    logic              m_valid_reg, m_valid_next;
    out_res_t          m_data_reg, m_data_next;

    logic [CNT_W-1:0]  n_used;
    cell_ctrl_t        ctrl;
    logic [MAX_PROCS-1:0] sel;
    cell_info_t        info [MAX_PROCS];
    ring_key_t         ring [MAX_PROCS];
    logic              accept, run_fin, any_busy, emit_load, admit_now;
    logic [IDX_W-1:0]  cur;

    always_comb begin
        if (pcount_reg == '0) begin
            n_used = CNT_W'(1);
        end else if (32'(pcount_reg) > MAX_PROCS) begin
            n_used = CNT_W'(MAX_PROCS);
        end else begin
            n_used = CNT_W'(pcount_reg);
        end
    end

    assign s_ready = state_reg == S_IDLE;
    assign accept  = s_valid && s_ready;
    assign cur     = idx_reg[IDX_W-1:0];

    genvar g;
    generate
        for (g = 0; g < MAX_PROCS; g++) begin : g_cell
            nps_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .ctrl    (ctrl),
                .sel     (sel[g]),
                .req     (s_data),
                .now     (now_reg),
                .ring_in (ring[(g + MAX_PROCS - 1) % MAX_PROCS]),
                .ring_out(ring[g]),
                .info    (info[g])
            );
        end
    endgenerate

    always_comb begin
        run_fin  = 1'b0;
        any_busy = 1'b0;
        for (int i = 0; i < MAX_PROCS; i++) begin
            run_fin = run_fin | info[i].head_fin;
            if (CNT_W'(i) < n_used) begin
                any_busy = any_busy | info[i].busy;
            end
        end
    end

    assign admit_now = (state_reg == S_ADMIT) && info[cur].eligible &&
                       (qlen_reg < CNT_W'(MAX_PROCS));
    assign emit_load = (state_reg == S_EMIT) && (!m_valid_reg || m_ready);

    always_comb begin
        ctrl            = '0;
        ctrl.load       = accept && (s_data.cmd == CMD_LOAD) &&
                          (CNT_W'(s_data.slot) < n_used) &&
                          !info[IDX_W'(s_data.slot)].queued;
        ctrl.admit      = admit_now;
        ctrl.admit_rank = qlen_reg + CNT_W'(1);
        ctrl.ring_load  = state_reg == S_RLOAD;
        ctrl.ring_step  = state_reg == S_RSHIFT;
        ctrl.commit     = state_reg == S_COMMIT;
        ctrl.run        = state_reg == S_RUN;
        ctrl.run_fin    = run_fin;
        for (int i = 0; i < MAX_PROCS; i++) begin
            sel[i] = (state_reg == S_IDLE) ? (IDX_W'(s_data.slot) == IDX_W'(i))
                                           : (cur == IDX_W'(i));
        end
    end

    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        qlen_next    = qlen_reg;
        now_next     = now_reg;
        tick_next    = tick_reg;
        done_next    = done_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (accept && s_data.cmd == CMD_TICK) begin
                    idx_next   = '0;
                    tick_next  = now_reg;
                    state_next = S_ADMIT;
                end
            end
            S_ADMIT: begin
                if (admit_now) begin
                    qlen_next = qlen_reg + CNT_W'(1);
                end
                idx_next = idx_reg + CNT_W'(1);
                if (idx_reg + CNT_W'(1) >= n_used) begin
                    state_next = S_RLOAD;
                end
            end
            S_RLOAD: begin
                idx_next   = '0;
                state_next = S_RSHIFT;
            end
            S_RSHIFT: begin
                idx_next = idx_reg + CNT_W'(1);
                if (idx_reg == CNT_W'(MAX_PROCS - 1)) begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT: begin
                state_next = S_RUN;
            end
            S_RUN: begin
                if (run_fin && qlen_reg != '0) begin
                    qlen_next = qlen_reg - CNT_W'(1);
                end
                if (now_reg != {TIME_W{1'b1}}) begin
                    now_next = now_reg + TIME_W'(1);
                end
                state_next = S_DONE;
            end
            S_DONE: begin
                done_next  = !any_busy;
                idx_next   = '0;
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (emit_load) begin
                    m_valid_next         = 1'b1;
                    m_data_next.tick_time = tick_reg;
                    m_data_next.slot_res = SLOT_W'(cur);
                    m_data_next.status   = info[cur].stat;
                    m_data_next.last     = idx_reg + CNT_W'(1) == n_used;
                    m_data_next.all_done = done_reg;
                    idx_next             = idx_reg + CNT_W'(1);
                    if (idx_reg + CNT_W'(1) == n_used) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            pcount_reg  <= PCNT_W'(16);
            idx_reg     <= '0;
            qlen_reg    <= '0;
            now_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            qlen_reg    <= qlen_next;
            now_reg     <= now_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                pcount_reg <= cfg_wr_data;
            end
        end
        tick_reg   <= tick_next;
        done_reg   <= done_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
`default_nettype wire

@@ tb/tb.sv @@
// ---------------------------------------------------------------------------
// tb: self-checking testbench of the nonpreemptive priority scheduler
// Drives load and tick requests with random gaps and output stalls, keeps
// its own model of the slots, the ready queue and the tick time, and checks
// every status row against the rows that model predicts.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb;
    import nps_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    in_req_t  s_data;
    logic     m_valid;
    logic     m_ready;
    out_res_t m_data;
    logic     cfg_wr_en;
    logic [PCNT_W-1:0] cfg_wr_data;

    nonpreemptive_priority_scheduler u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // Scheduler state as this testbench tracks it.
    logic [PCNT_W-1:0] sched_count;
    logic [DUR_W-1:0]  slot_left   [MAX_PROCS];
    logic [PRIO_W-1:0] slot_prio   [MAX_PROCS];
    logic [TIME_W-1:0] slot_arrive [MAX_PROCS];
    int                slot_rank   [MAX_PROCS];
    bit                slot_done   [MAX_PROCS];
    int                queue_len;
    logic [TIME_W-1:0] sched_time;

    out_res_t expected_rows[$];
    int       error_count;
    int       row_count;
    int       tick_count;
    int       idle_cycles;
    bit       stall_enable;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic int slots_in_use();
        if (sched_count < 1) return 1;
        if (sched_count > MAX_PROCS) return MAX_PROCS;
        return int'(sched_count);
    endfunction

    function automatic bit served_first(int a, int b);
        if (slot_prio[a] != slot_prio[b]) return slot_prio[a] < slot_prio[b];
        if (slot_arrive[a] != slot_arrive[b]) return slot_arrive[a] < slot_arrive[b];
        return slot_rank[a] < slot_rank[b];
    endfunction

    task automatic predict_request(input in_req_t req);
        int n;
        int r;
        int head;
        int new_rank[MAX_PROCS];
        logic [1:0] row_status[MAX_PROCS];
        bit finished;
        out_res_t row;
        n = slots_in_use();
        finished = 1'b1;
        head = -1;
        if (req.cmd == CMD_LOAD) begin
            if (int'(req.slot) < n && slot_rank[req.slot] == 0) begin
                slot_left[req.slot]   = req.duration;
                slot_prio[req.slot]   = req.priority_req;
                slot_arrive[req.slot] = req.arrival_time;
                slot_done[req.slot]   = 1'b0;
            end
            return;
        end
        for (int i = 0; i < n; i++) begin
            if (slot_rank[i] == 0 && !slot_done[i] && slot_left[i] != 0 &&
                slot_arrive[i] == sched_time && queue_len < MAX_PROCS) begin
                queue_len++;
                slot_rank[i] = queue_len;
            end
        end
        for (int i = 0; i < MAX_PROCS; i++) begin
            new_rank[i] = slot_rank[i];
            if (slot_rank[i] >= 2) begin
                r = 2;
                for (int j = 0; j < MAX_PROCS; j++)
                    if (j != i && slot_rank[j] >= 2 && served_first(j, i)) r++;
                new_rank[i] = r;
            end
        end
        for (int i = 0; i < MAX_PROCS; i++) begin
            slot_rank[i] = new_rank[i];
            row_status[i] = (slot_rank[i] == 1) ? ST_RUN :
                            (slot_rank[i] >= 2) ? ST_READY : ST_ABSENT;
            if (slot_rank[i] == 1) head = i;
        end
        if (head >= 0) begin
            if (slot_left[head] != 0) slot_left[head]--;
            if (slot_left[head] == 0) begin
                slot_done[head] = 1'b1;
                for (int i = 0; i < MAX_PROCS; i++)
                    if (slot_rank[i] != 0) slot_rank[i]--;
                if (queue_len != 0) queue_len--;
            end
        end
        for (int i = 0; i < n; i++)
            if (slot_left[i] != 0) finished = 1'b0;
        for (int i = 0; i < n; i++) begin
            row.tick_time = sched_time;
            row.slot_res  = SLOT_W'(i);
            row.status    = row_status[i];
            row.last      = (i == n - 1);
            row.all_done  = finished;
            expected_rows.push_back(row);
        end
        if (sched_time != '1) sched_time++;
        tick_count++;
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH tick %0d slot %0d: %s got %0d expected %0d",
                 m_data.tick_time, m_data.slot_res, what, got, want);
        error_count++;
    endtask

    function automatic int random_gap();
        if ($urandom_range(0, 3) == 0) return 0;
        if ($urandom_range(0, 9) == 0) return $urandom_range(8, 30);
        return $urandom_range(0, 2);
    endfunction

    // Checks each accepted status row against the oldest predicted row.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_rows.size() == 0) begin
                report_mismatch("unexpected row", 1, 0);
            end else begin
                out_res_t want;
                want = expected_rows.pop_front();
                if (m_data.tick_time != want.tick_time)
                    report_mismatch("tick_time", m_data.tick_time, want.tick_time);
                if (m_data.slot_res != want.slot_res)
                    report_mismatch("slot_res", m_data.slot_res, want.slot_res);
                if (m_data.status != want.status)
                    report_mismatch("status", m_data.status, want.status);
                if (m_data.last != want.last)
                    report_mismatch("last", m_data.last, want.last);
                if (m_data.all_done != want.all_done)
                    report_mismatch("all_done", m_data.all_done, want.all_done);
            end
            row_count++;
        end
    end

    // Random back-pressure on the result channel.
    always @(posedge aclk) begin
        if (!aresetn || !stall_enable) begin
            m_ready <= 1'b1;
        end else if ($urandom_range(0, 19) == 0) begin
            m_ready <= 1'b0;
        end else if (!m_ready && $urandom_range(0, 2) == 0) begin
            m_ready <= 1'b1;
        end else if ($urandom_range(0, 5) == 0) begin
            m_ready <= ~m_ready;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("TIMEOUT after %0d cycles without progress", idle_cycles);
                $display("nonpreemptive_priority_scheduler verification failed");
                $finish;
            end
        end
    end

    // Valid stays high after an accepted request when the next one follows
    // at once; callers that pause the input drop it themselves.
    task automatic send_request(input in_req_t req, input bit gaps);
        int gap;
        gap = gaps ? random_gap() : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_request(req);
    endtask

    task automatic load_slot(input int slot, input int dur, input int prio,
                             input int arrive, input bit gaps);
        in_req_t req;
        req.cmd          = CMD_LOAD;
        req.slot         = SLOT_W'(slot);
        req.duration     = DUR_W'(dur);
        req.priority_req = PRIO_W'(prio);
        req.arrival_time = TIME_W'(arrive);
        send_request(req, gaps);
    endtask

    task automatic tick_once(input bit gaps);
        in_req_t req;
        req = in_req_t'($urandom());
        req.cmd = CMD_TICK;
        send_request(req, gaps);
    endtask

    // Lets the block settle, then writes the slot count while it is idle.
    task automatic set_slot_count(input int value);
        s_valid <= 1'b0;
        while (expected_rows.size() != 0) @(posedge aclk);
        repeat (2 * MAX_PROCS + 40) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= PCNT_W'(value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        sched_count = PCNT_W'(value);
    endtask

    task automatic test_directed();
        set_slot_count(4);
        load_slot(0, 3, 5, 0, 1'b0);
        load_slot(1, 2, 1, 0, 1'b0);
        load_slot(2, 2, 1, 1, 1'b0);
        load_slot(3, 0, 0, 0, 1'b0);
        load_slot(9, 7, 7, 0, 1'b0);
        tick_once(1'b0);
        load_slot(0, 255, 255, 65535, 1'b0);
        load_slot(2, 1, 0, 2, 1'b0);
        repeat (8) tick_once(1'b0);
        set_slot_count(0);
        load_slot(0, 255, 0, 65535, 1'b0);
        tick_once(1'b0);
        set_slot_count(31);
        load_slot(15, 1, 255, 9, 1'b0);
        repeat (3) tick_once(1'b0);
    endtask

    task automatic test_random_schedules(input int count, input int span);
        int sent;
        int base;
        sent = 0;
        while (sent < count) begin
            base = int'(sched_time);
            for (int i = 0; i < slots_in_use() && sent < count; i++) begin
                if ($urandom_range(0, 2) != 0) begin
                    load_slot($urandom_range(0, 15),
                              ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                          : $urandom_range(0, 4),
                              ($urandom_range(0, 5) == 0) ? $urandom_range(0, 255)
                                                          : $urandom_range(0, 3),
                              ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                                          : base + $urandom_range(0, span),
                              1'b1);
                    sent++;
                end
            end
            repeat ($urandom_range(1, span + 3)) begin
                tick_once(1'b1);
                sent++;
            end
        end
    endtask

    // Loads slots whose arrival tick is the top of the time range.
    task automatic test_time_ceiling();
        set_slot_count(2);
        load_slot(0, 2, 3, 65535, 1'b0);
        load_slot(1, 1, 3, 65535, 1'b0);
    endtask

    initial begin
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_data       = '0;
        m_ready      = 1'b1;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        stall_enable = 1'b0;
        error_count  = 0;
        row_count    = 0;
        tick_count   = 0;
        idle_cycles  = 0;
        sched_count  = 16;
        queue_len    = 0;
        sched_time   = '0;
        for (int i = 0; i < MAX_PROCS; i++) begin
            slot_left[i] = '0; slot_prio[i] = '0; slot_arrive[i] = '0;
            slot_rank[i] = 0;  slot_done[i] = 1'b0;
        end
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        stall_enable = 1'b1;
        set_slot_count(16);
        test_random_schedules(80, 6);
        set_slot_count(5);
        test_random_schedules(60, 4);
        set_slot_count(1);
        test_random_schedules(30, 3);
        set_slot_count(16);
        test_random_schedules(50, 8);
        test_time_ceiling();
        s_valid <= 1'b0;

        while (expected_rows.size() != 0) @(posedge aclk);
        repeat (2 * MAX_PROCS + 40) @(posedge aclk);
        $display("Covered %0d ticks and %0d status rows across slot counts 0 to 31,",
                 tick_count, row_count);
        $display("with random request gaps and result back-pressure.");
        if (error_count == 0) begin
            $display("nonpreemptive_priority_scheduler verification clean");
        end else begin
            $display("nonpreemptive_priority_scheduler verification failed");
        end
        $finish;
    end
endmodule
`default_nettype wire

@@ filelist.f @@
rtl/core/nps_pkg.sv
rtl/core/nps_cell.sv
rtl/core/nonpreemptive_priority_scheduler.sv
tb/tb.sv
